// ===== hw/rtl/ebv_pkg.sv =====
// ebv_pkg: shared types and constants for the Euler-angle basis vector block.
// CORDIC word format, lane record and arctangent table.
// No dependencies.
package ebv_pkg;

    // Internal fixed point: Q2.30 in a 32-bit signed word
    localparam int INT_FRAC     = 30;
    localparam int CW           = 32;
    localparam int CORDIC_STEPS = 30;
    localparam int LANES        = 3;   // pitch, yaw, roll

    localparam int LANE_PITCH = 0;
    localparam int LANE_YAW   = 1;
    localparam int LANE_ROLL  = 2;

    // 1/K scaled to Q2.30
    localparam logic signed [CW-1:0] CORDIC_GAIN = 32'sd652032874;

    // atan(2^-i), 2^32 units per full turn
    localparam logic signed [CW-1:0] ATAN_TAB [CORDIC_STEPS] = '{
        32'sh20000000, 32'sh12E4051E, 32'sh09FB385B, 32'sh051111D4, 32'sh028B0D43,
        32'sh0145D7E1, 32'sh00A2F61E, 32'sh00517C55, 32'sh0028BE53, 32'sh00145F2F,
        32'sh000A2F98, 32'sh000517CC, 32'sh00028BE6, 32'sh000145F3, 32'sh0000A2F9,
        32'sh0000517C, 32'sh000028BE, 32'sh0000145F, 32'sh00000A2F, 32'sh00000517,
        32'sh0000028B, 32'sh00000145, 32'sh000000A2, 32'sh00000051, 32'sh00000028,
        32'sh00000014, 32'sh0000000A, 32'sh00000005, 32'sh00000002, 32'sh00000001
    };

    // One angle in flight through the rotator
    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic [1:0]           quad;
    } lane_t;

    typedef lane_t [LANES-1:0] lanes_t;

endpackage

// ===== hw/rtl/ebv_cordic_cell.sv =====
// ebv_cordic_cell: one rotation-mode CORDIC step for all three angles, registered.
// Elastic stage with its own valid bit. Depends on ebv_pkg.
module ebv_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            up_valid,
    output logic            up_ready,
    input  ebv_pkg::lanes_t up_lanes,
    output logic            dn_valid,
    input  logic            dn_ready,
    output ebv_pkg::lanes_t dn_lanes
);

    localparam logic signed [ebv_pkg::CW-1:0] ATAN = ebv_pkg::ATAN_TAB[STEP];

    logic            valid_reg;
    logic            valid_next;
    ebv_pkg::lanes_t lanes_reg;
    ebv_pkg::lanes_t lanes_next;

    assign up_ready = !valid_reg || dn_ready;

    always_comb
    begin
        for (int k = 0; k < ebv_pkg::LANES; k++)
        begin
            lanes_next[k].quad = up_lanes[k].quad;
            if (!up_lanes[k].z[ebv_pkg::CW-1])
            begin
                lanes_next[k].x = up_lanes[k].x - (up_lanes[k].y >>> STEP);
                lanes_next[k].y = up_lanes[k].y + (up_lanes[k].x >>> STEP);
                lanes_next[k].z = up_lanes[k].z - ATAN;
            end
            else
            begin
                lanes_next[k].x = up_lanes[k].x + (up_lanes[k].y >>> STEP);
                lanes_next[k].y = up_lanes[k].y - (up_lanes[k].x >>> STEP);
                lanes_next[k].z = up_lanes[k].z + ATAN;
            end
        end
    end

    assign valid_next = up_ready ? up_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready)
        begin
            lanes_reg <= lanes_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_lanes = lanes_reg;

endmodule

// ===== hw/rtl/ebv_basis.sv =====
// ebv_basis: quadrant fold, product network, sums and output rounding.
// Five elastic stages, the last one is the output register. Depends on ebv_pkg.
module ebv_basis #(
    parameter int FRAC_BITS = 14
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  ebv_pkg::lanes_t             in_lanes,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [FRAC_BITS+1:0] fwd_x,
    output logic signed [FRAC_BITS+1:0] fwd_y,
    output logic signed [FRAC_BITS+1:0] fwd_z,
    output logic signed [FRAC_BITS+1:0] right_x,
    output logic signed [FRAC_BITS+1:0] right_y,
    output logic signed [FRAC_BITS+1:0] right_z,
    output logic signed [FRAC_BITS+1:0] up_x,
    output logic signed [FRAC_BITS+1:0] up_y,
    output logic signed [FRAC_BITS+1:0] up_z
);

    localparam int CW     = ebv_pkg::CW;
    localparam int OUT_W  = FRAC_BITS + 2;
    localparam int SH     = ebv_pkg::INT_FRAC - FRAC_BITS;
    localparam int SUM_W  = CW + 2;
    localparam int NSTG   = 5;
    localparam int NCOMP  = 9;
    localparam logic signed [SUM_W-1:0] LIM  = SUM_W'(1) << FRAC_BITS;
    localparam logic signed [SUM_W-1:0] NLIM = -LIM;
    localparam logic signed [2*CW-1:0]  RND  = (2*CW)'(1) << (ebv_pkg::INT_FRAC - 1);

    typedef struct packed {
        logic signed [CW-1:0] s;
        logic signed [CW-1:0] c;
    } sc_t;

    typedef struct packed {
        logic signed [CW-1:0] srsp, crsp, cpcy, cpsy, crsy, crcy, srsy, srcy, srcp, crcp;
        logic signed [CW-1:0] sp, sy, cy;
    } m1_t;

    typedef struct packed {
        logic signed [CW-1:0] srspcy, srspsy, crspcy, crspsy;
        logic signed [CW-1:0] cpcy, cpsy, crsy, crcy, srsy, srcy, srcp, crcp, sp;
    } m2_t;

    // Q2.30 product, rounded half up
    function automatic logic signed [CW-1:0] qmul(input logic signed [CW-1:0] a,
                                                  input logic signed [CW-1:0] b);
        logic signed [2*CW-1:0] p;
        p = a * b + RND;
        return p[ebv_pkg::INT_FRAC+CW-1:ebv_pkg::INT_FRAC];
    endfunction

    // map first-quadrant result back to the full circle
    function automatic sc_t fold(input ebv_pkg::lane_t l);
        sc_t r;
        unique case (l.quad)
            2'd0:    begin r.c = l.x;  r.s = l.y;  end
            2'd1:    begin r.c = -l.y; r.s = l.x;  end
            2'd2:    begin r.c = -l.x; r.s = -l.y; end
            default: begin r.c = l.y;  r.s = -l.x; end
        endcase
        return r;
    endfunction

    logic [NSTG-1:0] v_reg;
    logic [NSTG-1:0] v_next;
    logic [NSTG-1:0] rdy;
    logic [NSTG-1:0] v_prev;

    sc_t [ebv_pkg::LANES-1:0] f_reg;
    sc_t [ebv_pkg::LANES-1:0] f_next;
    m1_t                      m1_reg;
    m1_t                      m1_next;
    m2_t                      m2_reg;
    m2_t                      m2_next;
    logic signed [SUM_W-1:0]  sum_reg [NCOMP];
    logic signed [SUM_W-1:0]  sum_next [NCOMP];
    logic signed [OUT_W-1:0]  out_reg [NCOMP];
    logic signed [OUT_W-1:0]  out_next [NCOMP];

    // ready ripples back from the output register
    always_comb
    begin
        rdy[NSTG-1] = !v_reg[NSTG-1] || !out_stall;
        for (int k = NSTG - 2; k >= 0; k--)
        begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
    end

    assign in_ready = rdy[0];
    assign v_prev   = {v_reg[NSTG-2:0], in_valid};

    always_comb
    begin
        for (int k = 0; k < NSTG; k++)
        begin
            v_next[k] = rdy[k] ? v_prev[k] : v_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    // fold
    always_comb
    begin
        for (int k = 0; k < ebv_pkg::LANES; k++)
        begin
            f_next[k] = fold(in_lanes[k]);
        end
    end

    // first products
    always_comb
    begin
        m1_next.srsp = qmul(f_reg[ebv_pkg::LANE_ROLL].s,  f_reg[ebv_pkg::LANE_PITCH].s);
        m1_next.crsp = qmul(f_reg[ebv_pkg::LANE_ROLL].c,  f_reg[ebv_pkg::LANE_PITCH].s);
        m1_next.cpcy = qmul(f_reg[ebv_pkg::LANE_PITCH].c, f_reg[ebv_pkg::LANE_YAW].c);
        m1_next.cpsy = qmul(f_reg[ebv_pkg::LANE_PITCH].c, f_reg[ebv_pkg::LANE_YAW].s);
        m1_next.crsy = qmul(f_reg[ebv_pkg::LANE_ROLL].c,  f_reg[ebv_pkg::LANE_YAW].s);
        m1_next.crcy = qmul(f_reg[ebv_pkg::LANE_ROLL].c,  f_reg[ebv_pkg::LANE_YAW].c);
        m1_next.srsy = qmul(f_reg[ebv_pkg::LANE_ROLL].s,  f_reg[ebv_pkg::LANE_YAW].s);
        m1_next.srcy = qmul(f_reg[ebv_pkg::LANE_ROLL].s,  f_reg[ebv_pkg::LANE_YAW].c);
        m1_next.srcp = qmul(f_reg[ebv_pkg::LANE_ROLL].s,  f_reg[ebv_pkg::LANE_PITCH].c);
        m1_next.crcp = qmul(f_reg[ebv_pkg::LANE_ROLL].c,  f_reg[ebv_pkg::LANE_PITCH].c);
        m1_next.sp   = f_reg[ebv_pkg::LANE_PITCH].s;
        m1_next.sy   = f_reg[ebv_pkg::LANE_YAW].s;
        m1_next.cy   = f_reg[ebv_pkg::LANE_YAW].c;
    end

    // three-factor products
    always_comb
    begin
        m2_next.srspcy = qmul(m1_reg.srsp, m1_reg.cy);
        m2_next.srspsy = qmul(m1_reg.srsp, m1_reg.sy);
        m2_next.crspcy = qmul(m1_reg.crsp, m1_reg.cy);
        m2_next.crspsy = qmul(m1_reg.crsp, m1_reg.sy);
        m2_next.cpcy   = m1_reg.cpcy;
        m2_next.cpsy   = m1_reg.cpsy;
        m2_next.crsy   = m1_reg.crsy;
        m2_next.crcy   = m1_reg.crcy;
        m2_next.srsy   = m1_reg.srsy;
        m2_next.srcy   = m1_reg.srcy;
        m2_next.srcp   = m1_reg.srcp;
        m2_next.crcp   = m1_reg.crcp;
        m2_next.sp     = m1_reg.sp;
    end

    // exact Q2.30 sums
    always_comb
    begin
        sum_next[0] = SUM_W'(m2_reg.cpcy);
        sum_next[1] = SUM_W'(m2_reg.cpsy);
        sum_next[2] = -SUM_W'(m2_reg.sp);
        sum_next[3] = SUM_W'(m2_reg.crsy) - SUM_W'(m2_reg.srspcy);
        sum_next[4] = -SUM_W'(m2_reg.srspsy) - SUM_W'(m2_reg.crcy);
        sum_next[5] = -SUM_W'(m2_reg.srcp);
        sum_next[6] = SUM_W'(m2_reg.crspcy) + SUM_W'(m2_reg.srsy);
        sum_next[7] = SUM_W'(m2_reg.crspsy) - SUM_W'(m2_reg.srcy);
        sum_next[8] = SUM_W'(m2_reg.crcp);
    end

    // round to the output format and clamp to +-1.0
    for (genvar g = 0; g < NCOMP; g++)
    begin : g_rnd
        logic signed [SUM_W-1:0] rnd;
        if (SH > 0)
        begin : g_sh
            localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) << (SH - 1);
            assign rnd = (sum_reg[g] + HALF) >>> SH;
        end
        else
        begin : g_full
            assign rnd = sum_reg[g];
        end
        always_comb
        begin
            priority if (rnd > LIM)
            begin
                out_next[g] = LIM[OUT_W-1:0];
            end
            else if (rnd < NLIM)
            begin
                out_next[g] = NLIM[OUT_W-1:0];
            end
            else
            begin
                out_next[g] = rnd[OUT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            f_reg <= f_next;
        end
        if (rdy[1])
        begin
            m1_reg <= m1_next;
        end
        if (rdy[2])
        begin
            m2_reg <= m2_next;
        end
        if (rdy[3])
        begin
            sum_reg <= sum_next;
        end
        if (rdy[4])
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = v_reg[NSTG-1];
    assign fwd_x     = out_reg[0];
    assign fwd_y     = out_reg[1];
    assign fwd_z     = out_reg[2];
    assign right_x   = out_reg[3];
    assign right_y   = out_reg[4];
    assign right_z   = out_reg[5];
    assign up_x      = out_reg[6];
    assign up_y      = out_reg[7];
    assign up_z      = out_reg[8];

endmodule

// ===== hw/rtl/euler_angles_to_basis_vectors.sv =====
// euler_angles_to_basis_vectors: pitch/yaw/roll binary angles to forward,
// right and up unit vectors in Q2.FRAC_BITS. Uses ebv_pkg, ebv_cordic_cell, ebv_basis.
//
//   channel  handshake                  payload
//   -------  -------------------------  ---------------------------------------
//   angles   angle_valid / angle_stall  pitch_angle, yaw_angle, roll_angle
//   vectors  vec_valid / vec_stall      fwd_xyz, right_xyz, up_xyz
//
// Throughput is one item per clock while vec_stall is low. Between accept
// and vec_valid lie 30 CORDIC cells plus fold, two product stages, sum, output.
// Every stage carries its own valid bit, so bubbles collapse while the output
// is stalled; angle_stall rises only once the whole chain is full and held.
// rst_n clears all valid bits asynchronously; data registers are not reset.
// No state survives between items.
module euler_angles_to_basis_vectors #(
    parameter int ANGLE_BITS = 16,
    parameter int FRAC_BITS  = 14
) (
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        angle_valid,
    output logic                        angle_stall,
    input  logic [ANGLE_BITS-1:0]       pitch_angle,
    input  logic [ANGLE_BITS-1:0]       yaw_angle,
    input  logic [ANGLE_BITS-1:0]       roll_angle,

    output logic                        vec_valid,
    input  logic                        vec_stall,
    output logic signed [FRAC_BITS+1:0] fwd_x,
    output logic signed [FRAC_BITS+1:0] fwd_y,
    output logic signed [FRAC_BITS+1:0] fwd_z,
    output logic signed [FRAC_BITS+1:0] right_x,
    output logic signed [FRAC_BITS+1:0] right_y,
    output logic signed [FRAC_BITS+1:0] right_z,
    output logic signed [FRAC_BITS+1:0] up_x,
    output logic signed [FRAC_BITS+1:0] up_y,
    output logic signed [FRAC_BITS+1:0] up_z
);

    localparam int CW    = ebv_pkg::CW;
    localparam int NCELL = ebv_pkg::CORDIC_STEPS;
    localparam int ASH   = CW - ANGLE_BITS;   // scale angle to 2^32 per turn

    // stage k data feeds cell k; stage NCELL feeds the product network
    ebv_pkg::lanes_t stage_lanes [NCELL+1];
    logic            stage_valid [NCELL+1];
    logic            stage_ready [NCELL+1];

    logic [CW-1:0]   ang32 [ebv_pkg::LANES];

    assign ang32[ebv_pkg::LANE_PITCH] = CW'(pitch_angle) << ASH;
    assign ang32[ebv_pkg::LANE_YAW]   = CW'(yaw_angle)   << ASH;
    assign ang32[ebv_pkg::LANE_ROLL]  = CW'(roll_angle)  << ASH;

    // top two bits pick the quadrant, the rest is the rotator's start angle
    always_comb
    begin
        for (int k = 0; k < ebv_pkg::LANES; k++)
        begin
            stage_lanes[0][k].x    = ebv_pkg::CORDIC_GAIN;
            stage_lanes[0][k].y    = '0;
            stage_lanes[0][k].z    = {2'b00, ang32[k][CW-3:0]};
            stage_lanes[0][k].quad = ang32[k][CW-1:CW-2];
        end
    end

    assign stage_valid[0] = angle_valid;
    assign angle_stall    = !stage_ready[0];

    for (genvar i = 0; i < NCELL; i++)
    begin : g_cell
        ebv_cordic_cell #(
            .STEP (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (stage_valid[i]),
            .up_ready (stage_ready[i]),
            .up_lanes (stage_lanes[i]),
            .dn_valid (stage_valid[i+1]),
            .dn_ready (stage_ready[i+1]),
            .dn_lanes (stage_lanes[i+1])
        );
    end

    ebv_basis #(
        .FRAC_BITS (FRAC_BITS)
    ) u_basis (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (stage_valid[NCELL]),
        .in_ready  (stage_ready[NCELL]),
        .in_lanes  (stage_lanes[NCELL]),
        .out_valid (vec_valid),
        .out_stall (vec_stall),
        .fwd_x     (fwd_x),
        .fwd_y     (fwd_y),
        .fwd_z     (fwd_z),
        .right_x   (right_x),
        .right_y   (right_y),
        .right_z   (right_z),
        .up_x      (up_x),
        .up_y      (up_y),
        .up_z      (up_z)
    );

endmodule

// ===== hw/rtl/ebv_checker.sv =====
// ebv_checker: port-level assertions for euler_angles_to_basis_vectors.
// Bound to the top level below. No package dependency.
module ebv_checker #(
    parameter int FRAC_BITS = 14
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        angle_stall,
    input logic                        vec_valid,
    input logic                        vec_stall,
    input logic signed [FRAC_BITS+1:0] fwd_x,
    input logic signed [FRAC_BITS+1:0] fwd_y,
    input logic signed [FRAC_BITS+1:0] fwd_z,
    input logic signed [FRAC_BITS+1:0] right_x,
    input logic signed [FRAC_BITS+1:0] right_y,
    input logic signed [FRAC_BITS+1:0] right_z,
    input logic signed [FRAC_BITS+1:0] up_x,
    input logic signed [FRAC_BITS+1:0] up_y,
    input logic signed [FRAC_BITS+1:0] up_z
);

    localparam int OUT_W = FRAC_BITS + 2;
    localparam logic signed [OUT_W-1:0] LIM  = OUT_W'(1) << FRAC_BITS;
    localparam logic signed [OUT_W-1:0] NLIM = -LIM;

    logic in_range;
    logic [9*OUT_W-1:0] payload;

    function automatic logic ok(input logic signed [OUT_W-1:0] v);
        return (v <= LIM) && (v >= NLIM);
    endfunction

    assign in_range = ok(fwd_x) && ok(fwd_y) && ok(fwd_z) && ok(right_x) && ok(right_y)
                   && ok(right_z) && ok(up_x) && ok(up_y) && ok(up_z);
    assign payload  = {fwd_x, fwd_y, fwd_z, right_x, right_y, right_z, up_x, up_y, up_z};

    // clamp keeps every component within +-1.0
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        vec_valid |-> in_range)
        else $error("component outside +-1.0");

    // input backs up only when the chain is full and the output is held
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        angle_stall |-> (vec_valid && vec_stall))
        else $error("input stalled with room in the chain");

    // nothing comes out straight after reset
    a_reset: assert property (@(posedge clk)
        !rst_n |=> !vec_valid)
        else $error("vec_valid right after reset");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (vec_valid && vec_stall) |=> (vec_valid && $stable(payload)))
        else $error("stalled item changed");

endmodule

bind euler_angles_to_basis_vectors ebv_checker #(
    .FRAC_BITS (FRAC_BITS)
) u_ebv_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .angle_stall (angle_stall),
    .vec_valid   (vec_valid),
    .vec_stall   (vec_stall),
    .fwd_x       (fwd_x),
    .fwd_y       (fwd_y),
    .fwd_z       (fwd_z),
    .right_x     (right_x),
    .right_y     (right_y),
    .right_z     (right_z),
    .up_x        (up_x),
    .up_y        (up_y),
    .up_z        (up_z)
);
